>>> sv/cepu_pkg.sv
// shared types and constants for the cobs event packet unpacker
package cepu_pkg;

  localparam int MAX_ENCODED_LEN_DEF = 256;
  localparam int MAX_CHANNELS_DEF    = 16;

  localparam int HEADER_LEN = 5;   // board id plus four event number bytes
  localparam int TS_LEN     = 12;  // decoded length of a timestamp packet
  localparam int BLOCK_LEN  = 9;   // channel number plus four 16-bit values
  localparam int COUNT_MAX  = 31;

  localparam logic [7:0] CODE_NO_ZERO = 8'hff;

  localparam logic [7:0] TS_BOARD_RST  = 8'hff;
  localparam logic [4:0] CHAN_LIM_RST  = 5'd16;

  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMESTAMP_BOARD,
    REG_CHANNEL_LIMIT
  } cepu_reg_t;

  typedef enum logic {
    KIND_READING,
    KIND_SUMMARY
  } cepu_kind_t;

  typedef enum logic [1:0] {
    PKT_UNKNOWN,
    PKT_ADC,
    PKT_TIMESTAMP
  } cepu_ptype_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TOO_SHORT,
    ST_BAD_LEN,
    ST_TOO_MANY,
    ST_OVERFLOW
  } cepu_status_t;

  typedef struct packed {
    logic [7:0] in_byte;
  } cepu_in_t;

  typedef struct packed {
    cepu_kind_t         kind;
    logic [7:0]         board_no;
    logic [31:0]        event_no;
    logic [7:0]         channel;
    logic signed [15:0] adc_a;
    logic signed [15:0] adc_b;
    logic signed [15:0] adc_c;
    logic signed [15:0] adc_t;
    logic [55:0]        timestamp;
    logic [4:0]         channel_count;
    cepu_ptype_t        packet_type;
    cepu_status_t       status;
  } cepu_result_t;

  typedef struct packed {
    logic [7:0] timestamp_board;
    logic [4:0] channel_limit;
  } cepu_cfg_t;

  // what the cobs stage hands to the parser for one byte
  typedef struct packed {
    logic       delim;      // packet delimiter, summary due
    logic       have;       // a decoded byte is present
    logic [7:0] data;
    logic       overflow;   // packet already flagged oversize
    logic       short_enc;  // at most one encoded byte so far
  } cepu_dec_t;

endpackage

>>> sv/cepu_stream_if.sv
// valid/ready stream channel with a typed payload
interface cepu_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/cepu_cobs_dec.sv
// cobs run tracking: turns encoded bytes into decoded bytes and packet flags
module cepu_cobs_dec
  import cepu_pkg::*;
#(
  parameter int MAX_ENCODED_LEN = MAX_ENCODED_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] in_byte,
  output cepu_dec_t  dec
);

  localparam int CNT_W = $clog2(MAX_ENCODED_LEN);
  localparam logic [CNT_W-1:0] ENC_LAST = CNT_W'(MAX_ENCODED_LEN - 1);

  logic [7:0]       bytes_left;
  logic [7:0]       prev_code;
  logic [CNT_W-1:0] enc_count;
  logic             overflow;

  logic [7:0]       bytes_left_next;
  logic [7:0]       prev_code_next;
  logic [CNT_W-1:0] enc_count_next;
  logic             overflow_next;

  always_comb begin
    bytes_left_next = bytes_left;
    prev_code_next  = prev_code;
    enc_count_next  = enc_count;
    overflow_next   = overflow;
    dec.delim       = 1'b0;
    dec.have        = 1'b0;
    dec.data        = '0;
    dec.overflow    = overflow;
    dec.short_enc   = (enc_count <= CNT_W'(1));
    if (in_byte == 8'd0) begin
      dec.delim       = 1'b1;
      bytes_left_next = '0;
      prev_code_next  = CODE_NO_ZERO;
      enc_count_next  = '0;
      overflow_next   = 1'b0;
    end else if (!overflow) begin
      if (enc_count >= ENC_LAST) begin
        overflow_next = 1'b1;
      end else begin
        enc_count_next = enc_count + CNT_W'(1);
        if (bytes_left != 8'd0) begin
          dec.have        = 1'b1;
          dec.data        = in_byte;
          bytes_left_next = bytes_left - 8'd1;
        end else begin
          // code byte: implied zero of the previous run, unless first or a full run
          dec.have        = (prev_code != CODE_NO_ZERO);
          prev_code_next  = in_byte;
          bytes_left_next = in_byte - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      prev_code  <= CODE_NO_ZERO;
      enc_count  <= '0;
      overflow   <= 1'b0;
    end else if (fire) begin
      bytes_left <= bytes_left_next;
      prev_code  <= prev_code_next;
      enc_count  <= enc_count_next;
      overflow   <= overflow_next;
    end
  end

endmodule

>>> sv/cepu_parser.sv
// packet field parser: header, channel blocks, timestamp and end summary
module cepu_parser
  import cepu_pkg::*;
#(
  parameter int MAX_ENCODED_LEN = MAX_ENCODED_LEN_DEF,
  parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  cepu_dec_t    dec,
  input  cepu_cfg_t    cfg,
  output logic         emit,
  output cepu_result_t res
);

  localparam int CNT_W = $clog2(MAX_ENCODED_LEN);
  localparam logic [3:0] BLOCK_LAST = 4'(BLOCK_LEN - 1);

  logic [CNT_W-1:0] dec_count;
  logic [7:0]       held_board;
  logic [31:0]      held_event;
  logic [3:0]       block_pos;
  logic [7:0]       held_channel;
  logic [63:0]      adc_bytes;
  logic [55:0]      held_ts;
  logic [4:0]       blocks_done;
  logic             too_many;

  logic [CNT_W-1:0] dec_count_next;
  logic [7:0]       held_board_next;
  logic [31:0]      held_event_next;
  logic [3:0]       block_pos_next;
  logic [7:0]       held_channel_next;
  logic [63:0]      adc_bytes_next;
  logic [55:0]      held_ts_next;
  logic [4:0]       blocks_done_next;
  logic             too_many_next;

  logic [1:0] ev_idx;
  logic [2:0] ts_idx;
  logic [2:0] adc_idx;
  logic [4:0] blocks_inc;
  logic       limit_hit;
  logic       is_ts;

  assign ev_idx     = dec_count[1:0] - 2'd1;
  assign ts_idx     = 3'(dec_count[3:0] - 4'd5);
  assign adc_idx    = 3'(block_pos - 4'd1);
  assign blocks_inc = (blocks_done == 5'(COUNT_MAX)) ? blocks_done : blocks_done + 5'd1;
  assign limit_hit  = (blocks_done >= cfg.channel_limit)
                   || (32'(blocks_done) >= 32'(MAX_CHANNELS));
  assign is_ts      = (held_board == cfg.timestamp_board);

  always_comb begin
    dec_count_next    = dec_count;
    held_board_next   = held_board;
    held_event_next   = held_event;
    block_pos_next    = block_pos;
    held_channel_next = held_channel;
    adc_bytes_next    = adc_bytes;
    held_ts_next      = held_ts;
    blocks_done_next  = blocks_done;
    too_many_next     = too_many;

    emit              = 1'b0;
    res               = '0;
    res.board_no      = held_board;
    res.event_no      = held_event;

    if (dec.delim) begin
      emit              = 1'b1;
      res.kind          = KIND_SUMMARY;
      res.channel_count = blocks_done;
      if (dec.overflow) begin
        res.packet_type = PKT_UNKNOWN;
        res.status      = ST_OVERFLOW;
      end else if (dec.short_enc || dec_count < CNT_W'(HEADER_LEN)) begin
        res.packet_type = PKT_UNKNOWN;
        res.status      = ST_TOO_SHORT;
      end else if (is_ts) begin
        res.packet_type   = PKT_TIMESTAMP;
        res.channel_count = '0;
        if (dec_count == CNT_W'(TS_LEN)) begin
          res.timestamp = held_ts;
          res.status    = ST_OK;
        end else begin
          res.status    = ST_BAD_LEN;
        end
      end else begin
        res.packet_type = PKT_ADC;
        if (too_many) begin
          res.status = ST_TOO_MANY;
        end else if (block_pos != 4'd0) begin
          res.status = ST_BAD_LEN;
        end else begin
          res.status = ST_OK;
        end
      end
      dec_count_next    = '0;
      held_board_next   = '0;
      held_event_next   = '0;
      block_pos_next    = '0;
      held_channel_next = '0;
      adc_bytes_next    = '0;
      held_ts_next      = '0;
      blocks_done_next  = '0;
      too_many_next     = 1'b0;
    end else if (dec.have) begin
      dec_count_next = dec_count + CNT_W'(1);
      if (dec_count == '0) begin
        held_board_next = dec.data;
      end else if (dec_count < CNT_W'(HEADER_LEN)) begin
        held_event_next[{ev_idx, 3'b000} +: 8] = dec.data;
      end else if (is_ts) begin
        if (dec_count < CNT_W'(TS_LEN)) begin
          held_ts_next[{ts_idx, 3'b000} +: 8] = dec.data;
        end
      end else if (block_pos == 4'd0) begin
        held_channel_next = dec.data;
        adc_bytes_next    = '0;
        block_pos_next    = 4'd1;
      end else begin
        adc_bytes_next[{adc_idx, 3'b000} +: 8] = dec.data;
        block_pos_next = block_pos + 4'd1;
        if (block_pos == BLOCK_LAST) begin
          // block complete
          block_pos_next   = 4'd0;
          blocks_done_next = blocks_inc;
          if (limit_hit) begin
            too_many_next = 1'b1;
          end else begin
            emit              = 1'b1;
            res.kind          = KIND_READING;
            res.channel       = held_channel;
            res.adc_a         = adc_bytes_next[15:0];
            res.adc_b         = adc_bytes_next[31:16];
            res.adc_c         = adc_bytes_next[47:32];
            res.adc_t         = adc_bytes_next[63:48];
            res.channel_count = blocks_inc;
            res.packet_type   = PKT_ADC;
            res.status        = ST_OK;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_count    <= '0;
      held_board   <= '0;
      held_event   <= '0;
      block_pos    <= '0;
      held_channel <= '0;
      adc_bytes    <= '0;
      held_ts      <= '0;
      blocks_done  <= '0;
      too_many     <= 1'b0;
    end else if (fire) begin
      dec_count    <= dec_count_next;
      held_board   <= held_board_next;
      held_event   <= held_event_next;
      block_pos    <= block_pos_next;
      held_channel <= held_channel_next;
      adc_bytes    <= adc_bytes_next;
      held_ts      <= held_ts_next;
      blocks_done  <= blocks_done_next;
      too_many     <= too_many_next;
    end
  end

endmodule

>>> sv/cobs_event_packet_unpacker_top.sv
// top level: input register, cobs stage, parser and result register
//
//   channel   role    payload          transaction
//   link      sink    in_byte          valid && ready
//   result    source  cepu_result_t    valid && ready
//   wr_*      write   index, data      wr_en high
//
// one byte per cycle while the result is not stalled: a byte taken from link is
// held in the input register, then the cobs stage and parser update their state
// and load the result register in one pass
// synchronous reset clears both registers' valid flags, all packet state and
// restores the configuration registers to their reset values
// a stalled result holds the parser; link stays ready while the input register
// can drain, so one extra byte is absorbed before link.ready drops
module cobs_event_packet_unpacker_top
  import cepu_pkg::*;
#(
  parameter int MAX_ENCODED_LEN = MAX_ENCODED_LEN_DEF,
  parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  cepu_stream_if.sink           link,
  cepu_stream_if.source         result,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  cepu_cfg_t    cfg;
  logic         in_valid;
  logic [7:0]   in_byte_q;
  logic         res_valid;
  cepu_result_t res_q;
  logic         fire;
  logic         emit;
  cepu_result_t res_comb;
  cepu_dec_t    dec;

  assign fire       = in_valid && (!res_valid || result.ready);
  assign link.ready = !in_valid || fire;

  assign result.valid   = res_valid;
  assign result.payload = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timestamp_board <= TS_BOARD_RST;
      cfg.channel_limit   <= CHAN_LIM_RST;
    end else if (wr_en) begin
      case (cepu_reg_t'(wr_index))
        REG_TIMESTAMP_BOARD: cfg.timestamp_board <= wr_data;
        REG_CHANNEL_LIMIT:   cfg.channel_limit   <= wr_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (link.valid && link.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (link.valid && link.ready) begin
      in_byte_q <= link.payload.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= emit;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res_q <= res_comb;
    end
  end

  cepu_cobs_dec #(
    .MAX_ENCODED_LEN(MAX_ENCODED_LEN)
  ) u_cobs_dec (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_byte (in_byte_q),
    .dec     (dec)
  );

  cepu_parser #(
    .MAX_ENCODED_LEN(MAX_ENCODED_LEN),
    .MAX_CHANNELS   (MAX_CHANNELS)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .dec  (dec),
    .cfg  (cfg),
    .emit (emit),
    .res  (res_comb)
  );

endmodule

>>> tb/tb.sv
// self-checking testbench for the cobs event packet unpacker
module tb;
  import cepu_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  // tracks the decoder and parser state and holds the results still owed
  class unpacker_scoreboard;
    logic [7:0]   ts_board   = TS_BOARD_RST;
    logic [4:0]   chan_limit = CHAN_LIM_RST;
    logic [7:0]   run_left   = '0;
    logic [7:0]   prev_code  = CODE_NO_ZERO;
    logic [8:0]   enc_count  = '0;
    logic [8:0]   dec_count  = '0;
    logic [7:0]   board      = '0;
    logic [31:0]  evt        = '0;
    logic [3:0]   blk_pos    = '0;
    logic [7:0]   chan       = '0;
    logic [63:0]  adc        = '0;
    logic [55:0]  stamp      = '0;
    logic [4:0]   blocks     = '0;
    bit           ovf        = 1'b0;
    bit           too_many   = 1'b0;
    cepu_result_t expected_results[$];
    int           errors     = 0;
    int           readings   = 0;
    int           status_seen[5] = '{default: 0};

    function void clear_packet();
      run_left  = '0;
      prev_code = CODE_NO_ZERO;
      enc_count = '0;
      dec_count = '0;
      board     = '0;
      evt       = '0;
      blk_pos   = '0;
      chan      = '0;
      adc       = '0;
      stamp     = '0;
      blocks    = '0;
      ovf       = 1'b0;
      too_many  = 1'b0;
    endfunction

    function void write_reg(cepu_reg_t idx, logic [7:0] val);
      if (idx == REG_TIMESTAMP_BOARD) ts_board = val;
      else chan_limit = val[4:0];
    endfunction

    function void push_summary();
      cepu_result_t e;
      e = '0;
      e.kind = KIND_SUMMARY;
      e.board_no = board;
      e.event_no = evt;
      e.channel_count = blocks;
      if (ovf) begin
        e.packet_type = PKT_UNKNOWN;
        e.status = ST_OVERFLOW;
      end else if (enc_count <= 1 || dec_count < HEADER_LEN) begin
        e.packet_type = PKT_UNKNOWN;
        e.status = ST_TOO_SHORT;
      end else if (board == ts_board) begin
        e.packet_type = PKT_TIMESTAMP;
        e.channel_count = '0;
        if (dec_count == TS_LEN) begin
          e.timestamp = stamp;
          e.status = ST_OK;
        end else begin
          e.status = ST_BAD_LEN;
        end
      end else begin
        e.packet_type = PKT_ADC;
        e.status = too_many ? ST_TOO_MANY : (blk_pos != 0 ? ST_BAD_LEN : ST_OK);
      end
      expected_results.push_back(e);
    endfunction

    function void take_decoded(logic [7:0] d);
      int p;
      int lim;
      cepu_result_t e;
      p = int'(dec_count);
      dec_count++;
      if (p == 0) begin
        board = d;
      end else if (p < HEADER_LEN) begin
        evt[8*(p-1) +: 8] = d;
      end else if (board == ts_board) begin
        if (p < TS_LEN) stamp[8*(p-HEADER_LEN) +: 8] = d;
      end else if (blk_pos == 0) begin
        chan = d;
        adc = '0;
        blk_pos = 4'd1;
      end else begin
        adc[8*(blk_pos-1) +: 8] = d;
        blk_pos++;
        if (blk_pos == BLOCK_LEN) begin
          blk_pos = 4'd0;
          lim = (chan_limit < MAX_CHANNELS_DEF) ? chan_limit : MAX_CHANNELS_DEF;
          if (blocks < COUNT_MAX) blocks++;
          if (blocks > lim) begin
            too_many = 1'b1;
          end else begin
            e = '0;
            e.kind = KIND_READING;
            e.board_no = board;
            e.event_no = evt;
            e.channel = chan;
            e.adc_a = adc[15:0];
            e.adc_b = adc[31:16];
            e.adc_c = adc[47:32];
            e.adc_t = adc[63:48];
            e.channel_count = blocks;
            e.packet_type = PKT_ADC;
            e.status = ST_OK;
            expected_results.push_back(e);
          end
        end
      end
    endfunction

    // returns 0 for a byte the block discards after an oversize packet
    function bit note_byte(logic [7:0] b);
      bit have;
      if (b == 8'h00) begin
        push_summary();
        clear_packet();
        return 1'b1;
      end
      if (ovf) return 1'b0;
      if (enc_count >= MAX_ENCODED_LEN_DEF - 1) begin
        ovf = 1'b1;
        return 1'b1;
      end
      enc_count++;
      if (run_left != 0) begin
        run_left--;
        have = 1'b1;
      end else begin
        // a new code byte stands for the zero that ended the last run
        have = (prev_code != CODE_NO_ZERO);
        prev_code = b;
        run_left = b - 8'd1;
        b = 8'h00;
      end
      if (have) take_decoded(b);
      return 1'b1;
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      end
    endfunction

    function void check_result(cepu_result_t got);
      cepu_result_t e;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none actual kind %0d status %0d",
                 $time, got.kind, got.status);
        return;
      end
      e = expected_results.pop_front();
      cmp("kind", 64'(e.kind), 64'(got.kind));
      cmp("board_no", 64'(e.board_no), 64'(got.board_no));
      cmp("event_no", 64'(e.event_no), 64'(got.event_no));
      cmp("channel", 64'(e.channel), 64'(got.channel));
      cmp("adc_a", 64'(e.adc_a), 64'(got.adc_a));
      cmp("adc_b", 64'(e.adc_b), 64'(got.adc_b));
      cmp("adc_c", 64'(e.adc_c), 64'(got.adc_c));
      cmp("adc_t", 64'(e.adc_t), 64'(got.adc_t));
      cmp("timestamp", 64'(e.timestamp), 64'(got.timestamp));
      cmp("channel_count", 64'(e.channel_count), 64'(got.channel_count));
      cmp("packet_type", 64'(e.packet_type), 64'(got.packet_type));
      cmp("status", 64'(e.status), 64'(got.status));
      if (e.kind == KIND_READING) readings++;
      else status_seen[e.status]++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  cepu_stream_if #(.payload_t(cepu_in_t))     link_ch();
  cepu_stream_if #(.payload_t(cepu_result_t)) res_ch();

  cobs_event_packet_unpacker_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .link     (link_ch),
    .result   (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  unpacker_scoreboard sb;
  int burst_left = 0;
  int bytes_taken = 0;
  int settings_used = 1;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int pkt_no = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("** cobs_event_packet_unpacker_top: FAILED **");
    $finish;
  end

  // receiver: ready pattern switches at random between four modes
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(8, 80);
      end
      rx_mode_left--;
      case (rx_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom_range(0, 1));
        2: res_ch.ready <= ($urandom_range(0, 7) == 0);
        default: res_ch.ready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // a result transaction completes at the next rising edge
  always @(negedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.payload);
  end

  task automatic push_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      link_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    link_ch.valid <= 1'b1;
    link_ch.payload.in_byte <= b;
    @(negedge clk);
    while (!link_ch.ready) @(negedge clk);
    @(posedge clk);
    burst_left--;
    if (sb.note_byte(b)) bytes_taken++;
  endtask

  task automatic send_raw(input octet_q_t q);
    foreach (q[i]) push_byte(q[i]);
  endtask

  // cobs-encode a decoded packet and send it with its delimiter
  task automatic send_packet(input octet_q_t pkt);
    octet_q_t enc;
    int code_at;
    logic [7:0] code;
    enc.push_back(8'h00);
    code_at = 0;
    code = 8'd1;
    foreach (pkt[i]) begin
      if (pkt[i] == 8'h00) begin
        enc[code_at] = code;
        code_at = enc.size();
        enc.push_back(8'h00);
        code = 8'd1;
      end else begin
        enc.push_back(pkt[i]);
        code++;
        if (code == CODE_NO_ZERO) begin
          enc[code_at] = code;
          code_at = enc.size();
          enc.push_back(8'h00);
          code = 8'd1;
        end
      end
    end
    enc[code_at] = code;
    enc.push_back(8'h00);
    send_raw(enc);
  endtask

  task automatic drain();
    int n;
    n = 0;
    link_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_results.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] ts, input logic [4:0] lim);
    wr_en <= 1'b1;
    wr_index <= REG_TIMESTAMP_BOARD;
    wr_data <= ts;
    @(posedge clk);
    sb.write_reg(REG_TIMESTAMP_BOARD, ts);
    wr_index <= REG_CHANNEL_LIMIT;
    wr_data <= {3'b000, lim};
    @(posedge clk);
    sb.write_reg(REG_CHANNEL_LIMIT, {3'b000, lim});
    wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] rand_data();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2) return 8'h00;
    if (r == 2) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_random(ref octet_q_t q, input int n);
    repeat (n) q.push_back(rand_data());
  endfunction

  task automatic random_packet();
    octet_q_t q;
    int sel;
    int lim;
    int n;
    logic [7:0] brd;
    lim = (sb.chan_limit < MAX_CHANNELS_DEF) ? sb.chan_limit : MAX_CHANNELS_DEF;
    pkt_no++;
    sel = $urandom_range(0, 15);
    brd = 8'($urandom_range(0, 255));
    if (brd == sb.ts_board) brd ^= 8'h01;
    if (pkt_no % 40 == 17) begin
      // near the encoded length limit, sometimes with a run that needs a full code
      n = $urandom_range(250, 258);
      if ($urandom_range(0, 1)) repeat (n) q.push_back(8'($urandom_range(1, 255)));
      else add_random(q, n);
      send_packet(q);
    end else if (sel <= 6) begin
      q.push_back(brd);
      add_random(q, 4);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim) : $urandom_range(0, 3);
      add_random(q, 9 * n);
      if ($urandom_range(0, 4) == 0) add_random(q, $urandom_range(1, 8));
      send_packet(q);
    end else if (sel <= 9) begin
      q.push_back(sb.ts_board);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) : TS_LEN - 1;
      add_random(q, n);
      send_packet(q);
    end else if (sel <= 11) begin
      if ($urandom_range(0, 2) == 0) begin
        q.push_back(8'($urandom_range(1, 255)));
        q.push_back(8'h00);
        send_raw(q);
      end else begin
        add_random(q, $urandom_range(0, HEADER_LEN - 1));
        send_packet(q);
      end
    end else if (sel <= 14) begin
      // line noise: raw bytes that need not form valid cobs
      add_random(q, $urandom_range(1, 20));
      q.push_back(8'h00);
      send_raw(q);
    end else begin
      q.push_back(brd);
      add_random(q, 4);
      add_random(q, 9 * (lim + $urandom_range(1, 2)));
      if ($urandom_range(0, 2) == 0) add_random(q, $urandom_range(1, 8));
      send_packet(q);
    end
  endtask

  initial begin
    int target;
    int n;
    logic [7:0] ts;
    logic [4:0] lim;
    sb = new;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    link_ch.valid = 1'b0;
    link_ch.payload = '0;
    res_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed packets at reset settings
    send_raw('{8'h00});
    send_raw('{8'h01, 8'h00});
    send_packet('{8'h12, 8'hff, 8'hff, 8'hff, 8'hff});
    send_packet('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h80, 8'hff, 8'h7f, 8'h00, 8'h00, 8'hff, 8'hff,
                  8'hff, 8'hff, 8'h7f, 8'h00, 8'h80, 8'h01, 8'h00, 8'hfe, 8'hff});
    send_packet('{8'h34, 8'h04, 8'h03, 8'h02, 8'h01,
                  8'h07, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88,
                  8'h09, 8'h00, 8'haa});
    send_packet('{8'hff, 8'h78, 8'h56, 8'h34, 8'h12,
                  8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
    send_packet('{8'hff, 8'h01, 8'h00, 8'h00, 8'h80,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5a});
    send_packet('{8'hff, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                  8'h09, 8'h0a});
    send_packet('{8'h21, 8'h01, 8'h02, 8'h03});
    drain();

    configure(8'h00, 5'd1);
    send_packet('{8'h05, 8'h01, 8'h00, 8'h00, 8'h00,
                  8'h01, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                  8'h02, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
                  8'h03, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28});
    send_packet('{8'h06, 8'h02, 8'h00, 8'h00, 8'h00,
                  8'h01, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                  8'h02, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
                  8'h03, 8'h21});
    send_packet('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    drain();

    configure(8'hff, 5'd0);
    send_packet('{8'h07, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h01, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08});
    drain();

    // random phases, one per register setting
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin ts = 8'h00; lim = 5'd16; end
        1: begin ts = 8'hff; lim = 5'd31; end
        2: begin ts = 8'h5a; lim = 5'd3;  end
        3: begin ts = 8'($urandom_range(0, 255)); lim = 5'd1; end
        4: begin ts = 8'($urandom_range(0, 255)); lim = 5'($urandom_range(0, 16)); end
        5: begin ts = 8'h80; lim = 5'd0; end
        default: begin ts = 8'($urandom_range(0, 255)); lim = 5'd16; end
      endcase
      configure(ts, lim);
      target = bytes_taken + 185;
      while (bytes_taken < target) random_packet();
      drain();
    end

    n = 0;
    while (sb.expected_results.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      sb.errors += sb.expected_results.size();
      $display("%0t: %0d expected results never arrived", $time, sb.expected_results.size());
    end

    $display("covered %0d link bytes under %0d register settings, %0d channel readings",
             bytes_taken, settings_used, sb.readings);
    $display("packet ends: ok %0d, too short %0d, bad length %0d, too many %0d, overflow %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_TOO_SHORT], sb.status_seen[ST_BAD_LEN],
             sb.status_seen[ST_TOO_MANY], sb.status_seen[ST_OVERFLOW]);
    if (sb.errors == 0) begin
      $display("** cobs_event_packet_unpacker_top: PASSED **");
    end else begin
      $display("** cobs_event_packet_unpacker_top: FAILED **");
    end
    $finish;
  end

endmodule
